// File: rtl/core/range_reverse_buffer_defines.svh
// Assertion macros for the range reverse buffer.
// Every use samples the clock of the block; RRB_ASSERT also uses its reset.
`ifndef RANGE_REVERSE_BUFFER_DEFINES_SVH
`define RANGE_REVERSE_BUFFER_DEFINES_SVH
`ifndef SYNTH
`define RRB_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rrb assertion failed");
`define RRB_ASSERT_NR(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("rrb assertion failed");
`else
`define RRB_ASSERT(label, prop)
`define RRB_ASSERT_NR(label, prop)
`endif
`endif

// File: rtl/core/rrb_pkg.sv
`timescale 1ns / 1ps
package rrb_pkg;

   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 6;
   localparam int LEN_W  = 7;

   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_ERR  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_REVERSE = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] char_in;
      logic [IDX_W-1:0]  range_start;
      logic [IDX_W-1:0]  range_end;
   } req_word_type;

   typedef struct packed {
      logic              status;
      logic [CHAR_W-1:0] char_out;
      logic [LEN_W-1:0]  fill_length;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_WAIT,
      ST_RD_LO,
      ST_RD_HI,
      ST_WR_LO,
      ST_WR_HI,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic decode;
      logic capture_char;
      logic rd_lo;
      logic rd_hi;
      logic wr_lo;
      logic wr_hi;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    err;
      logic    pair_left;
      logic    pair_more;
   } dp_status_type;

endpackage

// File: rtl/core/rrb_req_if.sv
`timescale 1ns / 1ps
interface rrb_req_if;
   import rrb_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/rrb_rsp_if.sv
`timescale 1ns / 1ps
interface rrb_rsp_if;
   import rrb_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/rrb_ram.sv
`timescale 1ns / 1ps
module rrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

endmodule

// File: rtl/core/rrb_ctrl.sv
`timescale 1ns / 1ps
module rrb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rrb_pkg::dp_status_type dp_status,
   output rrb_pkg::ctrl_cmd_type  ctrl_cmd
);
   import rrb_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl_cmd     = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.load_req = 1'b1;
               state_in          = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctrl_cmd.decode = 1'b1;
            if (dp_status.cmd == CMD_READ && !dp_status.err) begin
               state_in = ST_RD_WAIT;
            end else if (dp_status.cmd == CMD_REVERSE && !dp_status.err &&
                         dp_status.pair_left) begin
               state_in = ST_RD_LO;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RD_WAIT: begin
            ctrl_cmd.capture_char = 1'b1;
            state_in              = ST_FINISH;
         end
         ST_RD_LO: begin
            ctrl_cmd.rd_lo = 1'b1;
            state_in       = ST_RD_HI;
         end
         ST_RD_HI: begin
            ctrl_cmd.rd_hi = 1'b1;
            state_in       = ST_WR_LO;
         end
         ST_WR_LO: begin
            ctrl_cmd.wr_lo = 1'b1;
            state_in       = ST_WR_HI;
         end
         ST_WR_HI: begin
            ctrl_cmd.wr_hi = 1'b1;
            state_in       = dp_status.pair_more ? ST_RD_LO : ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               ctrl_cmd.load_rsp = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/rrb_datapath.sv
`timescale 1ns / 1ps
module rrb_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rrb_pkg::ctrl_cmd_type  ctrl_cmd,
   input  rrb_pkg::req_word_type  req_word,
   output rrb_pkg::dp_status_type dp_status,
   output rrb_pkg::rsp_word_type  rsp_word
);
   import rrb_pkg::*;

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int IW  = (CW > IDX_W) ? CW : IDX_W;
   localparam int IW1 = IW + 1;
   localparam int XW  = (CW > LEN_W) ? CW : LEN_W;

   cmd_type           cmd_ff, cmd_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [IW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CHAR_W-1:0] tmp_ff, tmp_in;
   logic              status_ff, status_in;
   logic [CHAR_W-1:0] rd_char_ff, rd_char_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic [IW-1:0]     count_w;
   logic [XW-1:0]     count_x;
   logic              lo_oob, hi_oob, full, err;
   logic              append_ok;

   logic              we;
   logic [AW-1:0]     waddr, raddr;
   logic [CHAR_W-1:0] wdata, rd_data;

   assign count_w = IW'(count_ff);
   assign count_x = XW'(count_ff);
   assign lo_oob  = lo_ff >= count_w;
   assign hi_oob  = hi_ff >= count_w;
   assign full    = count_ff == CW'(DEPTH);

   always_comb begin
      case (cmd_ff)
         CMD_CLEAR:   err = STAT_DONE;
         CMD_APPEND:  err = full;
         CMD_REVERSE: err = lo_oob || hi_oob;
         default:     err = lo_oob;
      endcase
   end

   assign append_ok = ctrl_cmd.decode && cmd_ff == CMD_APPEND && !err;

   assign dp_status.cmd       = cmd_ff;
   assign dp_status.err       = err;
   assign dp_status.pair_left = lo_ff < hi_ff;
   // true when the pair after the current one still has lo below hi
   assign dp_status.pair_more = ({1'b0, lo_ff} + IW1'(2)) < {1'b0, hi_ff};

   assign raddr = ctrl_cmd.rd_hi ? hi_ff[AW-1:0] : lo_ff[AW-1:0];
   assign we    = append_ok || ctrl_cmd.wr_lo || ctrl_cmd.wr_hi;

   always_comb begin
      if (ctrl_cmd.wr_hi) begin
         waddr = hi_ff[AW-1:0];
         wdata = tmp_ff;
      end else if (ctrl_cmd.wr_lo) begin
         waddr = lo_ff[AW-1:0];
         wdata = rd_data;
      end else begin
         waddr = count_ff[AW-1:0];
         wdata = ch_ff;
      end
   end

   rrb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock      (clock),
      .we         (we),
      .waddr      (waddr),
      .wdata      (wdata),
      .raddr      (raddr),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      cmd_in     = cmd_ff;
      ch_in      = ch_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      count_in   = count_ff;
      tmp_in     = tmp_ff;
      status_in  = status_ff;
      rd_char_in = rd_char_ff;
      rsp_in     = rsp_ff;
      if (ctrl_cmd.load_req) begin
         cmd_in = cmd_type'(req_word.cmd);
         ch_in  = req_word.char_in;
         lo_in  = IW'(req_word.range_start);
         hi_in  = IW'(req_word.range_end);
      end
      if (ctrl_cmd.decode) begin
         status_in  = err;
         rd_char_in = '0;
         if (cmd_ff == CMD_CLEAR) begin
            count_in = '0;
         end else if (append_ok) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (ctrl_cmd.capture_char) begin
         rd_char_in = rd_data;
      end
      if (ctrl_cmd.rd_hi) begin
         tmp_in = rd_data;
      end
      if (ctrl_cmd.wr_hi) begin
         lo_in = lo_ff + IW'(1);
         hi_in = hi_ff - IW'(1);
      end
      if (ctrl_cmd.load_rsp) begin
         rsp_in.status      = status_ff;
         rsp_in.char_out    = rd_char_ff;
         rsp_in.fill_length = count_x[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ch_ff      <= ch_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      tmp_ff     <= tmp_in;
      status_ff  <= status_in;
      rd_char_ff <= rd_char_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule

// File: rtl/core/range_reverse_buffer.sv
// Range reverse buffer: a byte store of DEPTH entries plus its fill length.
// req_chan carries one command word: clear, append char_in, reverse the
// inclusive range range_start..range_end in place, or read at range_start.
// rsp_chan returns one word per command: status (1 on full buffer or an
// index at or beyond the fill length), char_out (read data, else zero) and
// fill_length after the command.
// Clear, append and errors go from decode to the finish state; a read passes
// one wait state first; a reverse runs read low, read high, write low, write
// high per pair (pairs = (end - start + 1) / 2, at most DEPTH / 2). The store
// has one read and one write port, so each pair costs two reads and two writes.
// One command is worked at a time; a new word is accepted the cycle after
// the previous result is loaded into the output register.
// A result the receiver has not taken stays in the output register; the next
// command still runs and waits only at its end for that register to free.
// Reset empties the buffer (fill length zero) and drops any pending result;
// store contents are left as they are and are never read before rewritten.
`timescale 1ns / 1ps
`include "range_reverse_buffer_defines.svh"
module range_reverse_buffer #(
   parameter int DEPTH = 64
) (
   input logic         clock,
   input logic         reset,
   rrb_req_if.sink     req_chan,
   rrb_rsp_if.source   rsp_chan
);
   import rrb_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   rrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   rrb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl_cmd  (ctrl_cmd),
      .req_word  (req_chan.data),
      .dp_status (dp_status),
      .rsp_word  (rsp_chan.data)
   );

   `RRB_ASSERT(a_decode_after_accept, req_chan.valid && req_chan.ready |=> ctrl_cmd.decode)
   `RRB_ASSERT(a_swap_write_pair, ctrl_cmd.wr_lo |=> ctrl_cmd.wr_hi)
   `RRB_ASSERT(a_one_step, $onehot0(ctrl_cmd))
   `RRB_ASSERT(a_err_no_char, rsp_chan.valid && rsp_chan.data.status == STAT_ERR |-> rsp_chan.data.char_out == '0)

endmodule

// File: tb/sv/range_reverse_buffer_tb.sv
`timescale 1ns / 1ps
module range_reverse_buffer_tb;
   import rrb_pkg::*;

   localparam int DEPTH        = 64;
   localparam int IDLE_PCT     = 32;
   localparam int STALL_LIMIT  = 4000;
   localparam int RSP_HOLD_LEN = 400;
   localparam int TAIL_CYCLES  = 200;
   localparam int MAX_REPORTS  = 10;

   logic clock = 1'b0;
   logic reset;

   rrb_req_if req_bus ();
   rrb_rsp_if rsp_bus ();

   range_reverse_buffer #(.DEPTH(DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   logic [CHAR_W-1:0] text_mem [DEPTH];
   int                text_len;
   rsp_word_type      expected_rsp_q [$];
   int                mismatch_count = 0;
   int                stall_cycles = 0;
   int                rsp_hold_count = 0;
   bit                tx_idle_on = 1'b1;
   bit                rx_idle_on = 1'b1;

   always #5 clock = ~clock;

   // Buffer model: updates the text and length, returns the response word.
   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type      r;
      int                lo;
      int                hi;
      logic [CHAR_W-1:0] tmp;
      r.status   = STAT_DONE;
      r.char_out = '0;
      lo = w.range_start;
      hi = w.range_end;
      case (cmd_type'(w.cmd))
         CMD_CLEAR: begin
            text_len = 0;
         end
         CMD_APPEND: begin
            if (text_len >= DEPTH) begin
               r.status = STAT_ERR;
            end else begin
               text_mem[text_len] = w.char_in;
               text_len++;
            end
         end
         CMD_REVERSE: begin
            if (lo >= text_len || hi >= text_len) begin
               r.status = STAT_ERR;
            end else begin
               while (lo < hi) begin
                  tmp          = text_mem[lo];
                  text_mem[lo] = text_mem[hi];
                  text_mem[hi] = tmp;
                  lo++;
                  hi--;
               end
            end
         end
         default: begin
            if (lo >= text_len) begin
               r.status = STAT_ERR;
            end else begin
               r.char_out = text_mem[lo];
            end
         end
      endcase
      r.fill_length = LEN_W'(text_len);
      return r;
   endfunction

   function automatic req_word_type make_word(cmd_type c, logic [CHAR_W-1:0] ch,
                                              logic [IDX_W-1:0] s, logic [IDX_W-1:0] e);
      req_word_type w;
      w.cmd         = c;
      w.char_in     = ch;
      w.range_start = s;
      w.range_end   = e;
      return w;
   endfunction

   // Mostly in-range indices so reverses and reads do real work.
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      w.char_in     = CHAR_W'($urandom_range(255));
      w.range_start = IDX_W'($urandom_range(63));
      w.range_end   = IDX_W'($urandom_range(63));
      pick = $urandom_range(99);
      if (pick < 5) begin
         w.cmd = CMD_CLEAR;
      end else if (pick < 40) begin
         w.cmd = CMD_APPEND;
      end else begin
         w.cmd = (pick < 72) ? CMD_REVERSE : CMD_READ;
         if (text_len > 0 && $urandom_range(9) != 0) begin
            w.range_start = IDX_W'($urandom_range(text_len - 1));
            w.range_end   = IDX_W'($urandom_range(text_len - 1));
         end
      end
      return w;
   endfunction

   function automatic void report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t ns: %s", $time, msg);
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want !== got) begin
         report_mismatch($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
      end
   endfunction

   task automatic send_word(input req_word_type w);
      while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_rsp_q.push_back(predict_rsp(w));
   endtask

   task automatic send_random(input int count);
      repeat (count) send_word(random_word());
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   task automatic test_directed_cases();
      send_word(make_word(CMD_READ, 8'h00, 6'd0, 6'd0));
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd0, 6'd0));
      send_word(make_word(CMD_APPEND, 8'h00, 6'd63, 6'd63));
      send_word(make_word(CMD_APPEND, 8'hFF, 6'd0, 6'd0));
      send_word(make_word(CMD_APPEND, 8'hA5, 6'd0, 6'd0));
      send_word(make_word(CMD_APPEND, 8'h5A, 6'd0, 6'd0));
      send_word(make_word(CMD_APPEND, 8'h3C, 6'd0, 6'd0));
      send_word(make_word(CMD_READ, 8'hFF, 6'd4, 6'd63));
      send_word(make_word(CMD_READ, 8'h00, 6'd5, 6'd0));
      send_word(make_word(CMD_REVERSE, 8'hFF, 6'd0, 6'd4));
      send_word(make_word(CMD_READ, 8'h00, 6'd0, 6'd0));
      send_word(make_word(CMD_READ, 8'h00, 6'd4, 6'd0));
      // start past end, start equal to end: no-op, good status
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd3, 6'd1));
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd2, 6'd2));
      // end out of range, then start out of range with start above end
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd1, 6'd5));
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd5, 6'd1));
      send_word(make_word(CMD_READ, 8'h00, 6'd63, 6'd63));
      send_word(make_word(CMD_CLEAR, 8'hFF, 6'd63, 6'd63));
      send_word(make_word(CMD_READ, 8'h00, 6'd0, 6'd0));
      send_word(make_word(CMD_APPEND, 8'h81, 6'd63, 6'd63));
      send_word(make_word(CMD_READ, 8'h00, 6'd0, 6'd0));
   endtask

   task automatic test_full_buffer();
      send_word(make_word(CMD_CLEAR, 8'h00, 6'd0, 6'd0));
      repeat (DEPTH) begin
         send_word(make_word(CMD_APPEND, CHAR_W'($urandom_range(255)),
                             IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63))));
      end
      send_word(make_word(CMD_APPEND, 8'hEE, 6'd0, 6'd0));
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd0, 6'd63));
      send_word(make_word(CMD_READ, 8'h00, 6'd0, 6'd0));
      send_word(make_word(CMD_READ, 8'h00, 6'd63, 6'd0));
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd63, 6'd0));
      send_word(make_word(CMD_REVERSE, 8'h00, 6'd1, 6'd62));
      send_word(make_word(CMD_READ, 8'h00, 6'd62, 6'd0));
   endtask

   task automatic test_random_mix();
      send_random(650);
   endtask

   task automatic test_no_idle_burst();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_random(150);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // Receiver holds off; the sender keeps pushing until the block stalls it.
   task automatic test_rsp_backpressure();
      rsp_hold_count++;
      tx_idle_on = 1'b0;
      send_random(40);
      tx_idle_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      send_random(60);
      wait_drained();
      send_random(60);
   endtask

   initial begin : rsp_ready_drive
      int rsp_hold_seen;
      int rsp_hold_left;
      rsp_hold_seen = 0;
      rsp_hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_count != rsp_hold_seen) begin
            rsp_hold_seen = rsp_hold_count;
            rsp_hold_left = RSP_HOLD_LEN;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !rx_idle_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word: %p", rsp_bus.data));
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", want.status, rsp_bus.data.status);
            check_field("char_out", want.char_out, rsp_bus.data.char_out);
            check_field("fill_length", want.fill_length, rsp_bus.data.fill_length);
         end
      end
   end

   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("range_reverse_buffer_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      text_len = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_buffer();
      test_random_mix();
      test_no_idle_burst();
      test_rsp_backpressure();
      test_drain_pause();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("range_reverse_buffer_tb passed");
      end else begin
         $display("range_reverse_buffer_tb failed");
      end
      $finish;
   end

endmodule
